// ===== hdl/fuzzy_cmeans_membership_defines.svh =====
// assertion macros for the fuzzy c-means membership block
`ifndef FUZZY_CMEANS_MEMBERSHIP_DEFINES_SVH
`define FUZZY_CMEANS_MEMBERSHIP_DEFINES_SVH

// same-cycle implication
`define FCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcm assertion failed");

// next-cycle implication
`define FCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcm assertion failed");

`endif

// ===== hdl/fcm_pkg.sv =====
// shared types and constants for the fuzzy c-means membership block
package fcm_pkg;

  localparam int NUM_CLUSTERS_DEF = 4;
  localparam int TABLE_DEPTH_DEF  = 32;
  localparam int FEATS            = 4;
  localparam int CENT_BASE        = 8;
  localparam int DIV_W            = 39;
  localparam int SQ_IN_W          = 34;
  localparam int SQ_OUT_W         = SQ_IN_W / 2;
  localparam int DIST_W           = SQ_OUT_W + 1;
  localparam int ADDR_W           = 8;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [4:0]         param_index;
    logic signed [15:0] param_value;
    logic [3:0]         knight_count;
    logic [3:0]         bishop_count;
    logic [3:0]         rook_count;
    logic [3:0]         queen_count;
  } fcm_item_t;

  typedef struct packed {
    logic [3:0]  cluster_index;
    logic [15:0] membership;
    logic        last;
  } fcm_result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fcm_unit_stat_t;

endpackage

// ===== hdl/fuzzy_cmeans_membership.sv =====
// fuzzy c-means membership: parameter table, sequencer, shared divider and root
// load: table written as the item is accepted, next item taken in the following cycle
// classify: new items stall until the memberships of all N clusters are out, computed
//   with the bit-serial divider and the bit-serial square root
// reset clears the sequencer and result slot; the table holds no reset value
`include "fuzzy_cmeans_membership_defines.svh"

module fuzzy_cmeans_membership #(
  parameter int NUM_CLUSTERS = fcm_pkg::NUM_CLUSTERS_DEF,
  parameter int TABLE_DEPTH  = fcm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  fcm_pkg::fcm_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output fcm_pkg::fcm_result_t result
);
  import fcm_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CIW = $clog2(NUM_CLUSTERS);
  localparam logic [3:0] LAST_CI = 4'(NUM_CLUSTERS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NM   = 4'd1;
  localparam logic [3:0] S_NS   = 4'd2;
  localparam logic [3:0] S_NG   = 4'd3;
  localparam logic [3:0] S_NW   = 4'd4;
  localparam logic [3:0] S_DA   = 4'd5;
  localparam logic [3:0] S_DS   = 4'd6;
  localparam logic [3:0] S_DC   = 4'd7;
  localparam logic [3:0] S_SW   = 4'd8;
  localparam logic [3:0] S_MI   = 4'd9;
  localparam logic [3:0] S_MR   = 4'd10;
  localparam logic [3:0] S_MW   = 4'd11;
  localparam logic [3:0] S_MF   = 4'd12;
  localparam logic [3:0] S_MD   = 4'd13;
  localparam logic [3:0] S_MO   = 4'd14;

  logic [3:0] state;

  logic [15:0] mem [TABLE_DEPTH];
  logic [15:0] mem_q;
  logic        rd_oob;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic        wr_en;
  logic signed [15:0] rdata;

  logic [3:0][3:0]          cnt_r;
  logic [1:0]               f;
  logic [CIW-1:0]           ci;
  logic [CIW-1:0]           cj;
  logic signed [15:0]       mean_r;
  logic                     neg_r;
  logic signed [15:0]       norm [FEATS];
  logic [SQ_IN_W-1:0]       sq_r;
  logic [SQ_IN_W-1:0]       sum;
  logic [SQ_IN_W-1:0]       sum_add;
  logic [DIST_W-1:0]        cdist [NUM_CLUSTERS];
  logic [DIST_W-1:0]        dist_sel;
  logic [DIST_W-1:0]        di;
  logic [DIV_W-1:0]         s_acc;
  logic [15:0]              memb;

  logic [3:0]               cnt_sel;
  logic signed [17:0]       nd;
  logic [16:0]              nd_mag;
  logic [15:0]              sd_mag;
  logic signed [16:0]       diff;
  logic [16:0]              diff_mag;
  logic [15:0]              nq;

  logic                     div_start;
  logic [DIV_W-1:0]         div_num;
  logic [DIV_W-1:0]         div_den;
  logic [DIV_W-1:0]         div_quo;
  fcm_unit_stat_t           div_stat;
  logic                     sq_start;
  logic [SQ_OUT_W-1:0]      sq_root;
  fcm_unit_stat_t           sq_stat;
  logic                     load_res;
  logic                     accept;

  assign accept     = item_valid && !item_stall;
  assign item_stall = state != S_IDLE;

  // parameter table
  assign waddr = ADDR_W'(item.param_index);
  assign wr_en = accept && item.cmd == CMD_LOAD && waddr < ADDR_W'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr[AW-1:0]] <= item.param_value;
    end
    mem_q  <= mem[raddr[AW-1:0]];
    rd_oob <= raddr >= ADDR_W'(TABLE_DEPTH);
  end

  assign rdata = rd_oob ? 16'sd0 : mem_q;

  always_comb begin
    case (state)
      S_NM:    raddr = ADDR_W'({f, 1'b0});
      S_NS:    raddr = ADDR_W'({f, 1'b1});
      S_DA:    raddr = ADDR_W'(CENT_BASE) + (ADDR_W'(ci) << 2) + ADDR_W'(f);
      default: raddr = '0;
    endcase
  end

  // datapath helpers
  always_comb begin
    case (f)
      2'd0:    cnt_sel = cnt_r[0];
      2'd1:    cnt_sel = cnt_r[1];
      2'd2:    cnt_sel = cnt_r[2];
      default: cnt_sel = cnt_r[3];
    endcase
  end

  assign nd       = $signed({6'b0, cnt_sel, 8'b0}) - 18'(mean_r);
  assign nd_mag   = nd[17] ? 17'(-nd) : nd[16:0];
  assign sd_mag   = rdata[15] ? 16'(-rdata) : rdata;
  assign diff     = 17'(rdata) - 17'(norm[f]);
  assign diff_mag = diff[16] ? 17'(-diff) : diff;
  assign sum_add  = sum + sq_r;
  assign nq       = 16'd0 - div_quo[15:0];
  assign dist_sel = cdist[(state == S_MI) ? ci : cj];

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_NG: begin
        div_start = rdata != 16'sd0;
        div_num   = DIV_W'({nd_mag, 8'b0});
        div_den   = DIV_W'(sd_mag);
      end
      S_MR: begin
        div_start = 1'b1;
        div_num   = DIV_W'({di, 16'b0});
        div_den   = DIV_W'(dist_sel);
      end
      S_MF: begin
        div_start = 1'b1;
        div_num   = DIV_W'(1) << 32;
        div_den   = s_acc;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sq_start = state == S_DC && f == 2'd3;
  assign load_res = state == S_MO && (!result_valid || !result_stall);

  fcm_div #(.W(DIV_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  fcm_sqrt #(.IW(SQ_IN_W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sum_add),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      f     <= '0;
      ci    <= '0;
      cj    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && item.cmd == CMD_CLASSIFY) begin
            f     <= '0;
            state <= S_NM;
          end
        end
        S_NM: state <= S_NS;
        S_NS: state <= S_NG;
        S_NG: begin
          if (rdata == 16'sd0) begin
            if (f == 2'd3) begin
              f     <= '0;
              ci    <= '0;
              state <= S_DA;
            end else begin
              f     <= f + 1'b1;
              state <= S_NM;
            end
          end else begin
            state <= S_NW;
          end
        end
        S_NW: begin
          if (div_stat.done) begin
            if (f == 2'd3) begin
              f     <= '0;
              ci    <= '0;
              state <= S_DA;
            end else begin
              f     <= f + 1'b1;
              state <= S_NM;
            end
          end
        end
        S_DA: state <= S_DS;
        S_DS: state <= S_DC;
        S_DC: begin
          f     <= f + 1'b1;
          state <= (f == 2'd3) ? S_SW : S_DA;
        end
        S_SW: begin
          if (sq_stat.done) begin
            if (ci == CIW'(NUM_CLUSTERS - 1)) begin
              ci    <= '0;
              state <= S_MI;
            end else begin
              ci    <= ci + 1'b1;
              state <= S_DA;
            end
          end
        end
        S_MI: begin
          cj    <= '0;
          state <= S_MR;
        end
        S_MR: state <= S_MW;
        S_MW: begin
          if (div_stat.done) begin
            if (cj == CIW'(NUM_CLUSTERS - 1)) begin
              state <= S_MF;
            end else begin
              cj    <= cj + 1'b1;
              state <= S_MR;
            end
          end
        end
        S_MF: state <= S_MD;
        S_MD: begin
          if (div_stat.done) begin
            state <= S_MO;
          end
        end
        S_MO: begin
          if (load_res) begin
            if (ci == CIW'(NUM_CLUSTERS - 1)) begin
              state <= S_IDLE;
            end else begin
              ci    <= ci + 1'b1;
              state <= S_MI;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && item.cmd == CMD_CLASSIFY) begin
      cnt_r[0] <= item.knight_count;
      cnt_r[1] <= item.bishop_count;
      cnt_r[2] <= item.rook_count;
      cnt_r[3] <= item.queen_count;
    end
    if (state == S_NS) begin
      mean_r <= rdata;
    end
    if (state == S_NG) begin
      neg_r <= nd[17] ^ rdata[15];
      if (rdata == 16'sd0) begin
        norm[f] <= 16'sd0;
      end
    end
    if (state == S_NW && div_stat.done) begin
      if (!neg_r) begin
        norm[f] <= (div_quo > DIV_W'(32767)) ? 16'sh7FFF : div_quo[15:0];
      end else begin
        norm[f] <= (div_quo > DIV_W'(32768)) ? 16'sh8000 : nq;
      end
    end
    if (state == S_DS) begin
      sq_r <= SQ_IN_W'(diff_mag * diff_mag);
    end
    if (state == S_DA && f == 2'd0) begin
      sum <= '0;
    end else if (state == S_DC) begin
      sum <= sum_add;
    end
    if (state == S_SW && sq_stat.done) begin
      cdist[ci] <= DIST_W'(sq_root) + 1'b1;
    end
    if (state == S_MI) begin
      di    <= dist_sel;
      s_acc <= '0;
    end
    if (state == S_MW && div_stat.done) begin
      s_acc <= s_acc + div_quo;
    end
    if (state == S_MD && div_stat.done) begin
      memb <= (div_quo > DIV_W'(65535)) ? 16'hFFFF : div_quo[15:0];
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_res) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      result.cluster_index <= 4'(ci);
      result.membership    <= memb;
      result.last          <= ci == CIW'(NUM_CLUSTERS - 1);
    end
  end

  `FCM_ASSERT_NOW(a_div_free, div_start, !div_stat.busy)
  `FCM_ASSERT_NOW(a_sq_free, sq_start, !sq_stat.busy)
  `FCM_ASSERT_NOW(a_last_idx, result_valid && result.last, result.cluster_index == LAST_CI)
  `FCM_ASSERT_NEXT(a_busy_after, accept && item.cmd == CMD_CLASSIFY, item_stall)

endmodule

// ===== hdl/fcm_div.sv =====
// shared restoring divider, one quotient bit per cycle
module fcm_div #(
  parameter int W = fcm_pkg::DIV_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [W-1:0]            num,
  input  logic [W-1:0]            den,
  output fcm_pkg::fcm_unit_stat_t stat,
  output logic [W-1:0]            quo
);
  import fcm_pkg::*;

  localparam int CW = $clog2(W);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  dv;
  logic [W:0]    shifted;
  logic          fits;

  assign shifted = {rem, quo[W-1]};
  assign fits    = shifted >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dv  <= den;
    end else if (busy) begin
      rem <= fits ? W'(shifted - {1'b0, dv}) : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hdl/fcm_sqrt.sv =====
// digit-by-digit integer square root, one root bit per cycle
module fcm_sqrt #(
  parameter int IW = fcm_pkg::SQ_IN_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [IW-1:0]           value,
  output fcm_pkg::fcm_unit_stat_t stat,
  output logic [IW/2-1:0]         root
);
  import fcm_pkg::*;

  localparam int RW = IW / 2;
  localparam int CW = $clog2(RW);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [IW-1:0] src;
  logic [RW:0]   rem;
  logic [RW+2:0] shifted;
  logic [RW+2:0] trial;
  logic          fits;

  assign shifted = {rem, src[IW-1:IW-2]};
  assign trial   = (RW+3)'({root, 2'b01});
  assign fits    = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      root <= '0;
      src  <= value;
    end else if (busy) begin
      rem  <= fits ? (RW+1)'(shifted - trial) : (RW+1)'(shifted);
      root <= {root[RW-2:0], fits};
      src  <= {src[IW-3:0], 2'b00};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
